FILE: src/nfcq_pkg.sv
// Package with the shared types, widths and constants of the nearest-first chunk queue.
`default_nettype none
package nfcq_pkg;

	localparam int TABLE_DEPTH     = 64;
	localparam int CHUNK_EDGE      = 16;
	localparam int CHUNK_HALF_EDGE = 8;

	localparam int TAG_W    = 16;
	localparam int COORD_W  = 12;
	localparam int POS_W    = 20;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 7;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	localparam int CENTRE_MUL = CHUNK_EDGE * 16;
	localparam int CENTRE_OFS = CHUNK_HALF_EDGE * 16;
	localparam int SCALED_W   = COORD_W + $clog2(CENTRE_MUL);
	localparam int DIFF_W     = ((POS_W > SCALED_W) ? POS_W : SCALED_W) + 2;
	localparam int SQ_W       = 2 * DIFF_W - 2;
	localparam int SUM_W      = SQ_W + 2;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0]          tag;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                 tab_we;
		logic [IDX_W-1:0]     tab_waddr;
		logic                 rank_we;
		logic [IDX_W-1:0]     rank_waddr;
		logic [CNT_W-1:0]     rank_wdata;
		logic [IDX_W-1:0]     raddr;
	} mem_ctl_t;

	function automatic logic [IDX_W-1:0] first_free(input logic [TABLE_DEPTH-1:0] valid);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/nfcq_req_if.sv
// Request channel interface carrying push and pop words into the queue.
`default_nettype none
interface nfcq_req_if;
	import nfcq_pkg::*;

	logic                      valid;
	logic                      ready;
	op_t                       op;
	logic [TAG_W-1:0]          chunk_tag;
	logic signed [COORD_W-1:0] chunk_x;
	logic signed [COORD_W-1:0] chunk_y;
	logic signed [COORD_W-1:0] chunk_z;
	logic signed [POS_W-1:0]   player_x;
	logic signed [POS_W-1:0]   player_y;
	logic signed [POS_W-1:0]   player_z;

	modport source (
		output valid, op, chunk_tag, chunk_x, chunk_y, chunk_z,
		output player_x, player_y, player_z,
		input  ready
	);

	modport sink (
		input  valid, op, chunk_tag, chunk_x, chunk_y, chunk_z,
		input  player_x, player_y, player_z,
		output ready
	);

endinterface
`default_nettype wire

FILE: src/nfcq_rsp_if.sv
// Response channel interface carrying one result word per request.
`default_nettype none
interface nfcq_rsp_if;
	import nfcq_pkg::*;

	logic                      valid;
	logic                      ready;
	status_t                   status;
	logic [TAG_W-1:0]          out_tag;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;
	logic [OCC_W-1:0]          occupancy;

	modport source (
		output valid, status, out_tag, out_x, out_y, out_z, occupancy,
		input  ready
	);

	modport sink (
		input  valid, status, out_tag, out_x, out_y, out_z, occupancy,
		output ready
	);

endinterface
`default_nettype wire

FILE: src/nearest_first_chunk_queue.sv
// Top level of the nearest-first chunk queue: control, scan pipeline and result register.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    op, chunk_tag, chunk_x/y/z, player_x/y/z
//   rsp      out  valid/ready    status, out_tag, out_x/y/z, occupancy
//
// A push, a full push and a pop on an empty table go from idle straight to the response state.
// A pop reads one entry per cycle from the table RAM, then the distance pipeline drains,
// and the winner is removed and reported.
// Arrival ranks are compacted lazily during the next scan, so no extra pass is needed.
// Reset clears the valid bits and the count at once; there is no clearing pass.
// A new word is taken while the previous result still waits in the output register.
`default_nettype none
module nearest_first_chunk_queue (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nfcq_req_if.sink   req,
	nfcq_rsp_if.source rsp
);
	import nfcq_pkg::*;

	state_t state_q, state_d;
	mem_ctl_t ctl;

	logic [TABLE_DEPTH-1:0] entry_valid_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       scan_q;
	logic                   pend_q;
	logic [CNT_W-1:0]       pend_rank_q;

	logic signed [POS_W-1:0] px_q, py_q, pz_q;

	entry_t           tab_wdata, tab_rdata;
	logic [CNT_W-1:0] rank_rdata, rank_virt_s1, push_rank;

	logic             accept, is_pop, full;
	logic [IDX_W-1:0] free_idx;

	logic             v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic             live_s2, live_s3, live_s4;
	logic [CNT_W-1:0] rank_s2, rank_s3, rank_s4;
	entry_t           ent_s2, ent_s3, ent_s4;
	logic [SUM_W-1:0] dist_s4;
	logic             better;

	logic             found_q;
	logic [SUM_W-1:0] best_d_q;
	logic [CNT_W-1:0] best_rank_q;
	logic [IDX_W-1:0] best_idx_q;
	entry_t           best_ent_q;

	status_t          res_status_q;
	entry_t           res_ent_q;
	logic             out_v_q, out_load;
	status_t          out_status_q;
	entry_t           out_ent_q;
	logic [OCC_W-1:0] out_occ_q;

	assign accept   = req.valid && req.ready;
	assign is_pop   = (req.op == OP_POP);
	assign full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign free_idx = first_free(entry_valid_q);
	assign out_load = (state_q == S_RESP) && (!out_v_q || rsp.ready);

	assign tab_wdata.tag = req.chunk_tag;
	assign tab_wdata.x   = req.chunk_x;
	assign tab_wdata.y   = req.chunk_y;
	assign tab_wdata.z   = req.chunk_z;

	// Entries stored after an unfinished removal carry a rank one higher, so that the
	// pending decrement applied in the next scan brings them to their true place.
	assign push_rank    = pend_q ? count_q + CNT_W'(1) : count_q;
	assign rank_virt_s1 = (pend_q && (rank_rdata > pend_rank_q)) ?
		rank_rdata - CNT_W'(1) : rank_rdata;

	assign better = v_s4 && live_s4 &&
		(!found_q || (dist_s4 < best_d_q) ||
		((dist_s4 == best_d_q) && (rank_s4 < best_rank_q)));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (is_pop && (count_q != '0)) ? S_SCAN : S_RESP;
				end
			end
			S_SCAN: begin
				if (scan_q == IDX_W'(TABLE_DEPTH - 1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!(v_s1 || v_s2 || v_s3 || v_s4)) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_v_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready      = (state_q == S_IDLE);
		ctl.raddr      = scan_q;
		ctl.tab_we     = accept && !is_pop && !full;
		ctl.tab_waddr  = free_idx;
		ctl.rank_we    = ctl.tab_we || v_s1;
		ctl.rank_waddr = ctl.tab_we ? free_idx : idx_s1;
		ctl.rank_wdata = ctl.tab_we ? push_rank : rank_virt_s1;
	end

	nfcq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ctl.tab_we),
		.waddr (ctl.tab_waddr),
		.wdata (tab_wdata),
		.raddr (ctl.raddr),
		.rdata (tab_rdata)
	);

	nfcq_ram #(
		.WIDTH (CNT_W),
		.DEPTH (TABLE_DEPTH)
	) u_rank (
		.clk   (clk),
		.we    (ctl.rank_we),
		.waddr (ctl.rank_waddr),
		.wdata (ctl.rank_wdata),
		.raddr (ctl.raddr),
		.rdata (rank_rdata)
	);

	nfcq_dist u_dist (
		.clk     (clk),
		.px      (px_q),
		.py      (py_q),
		.pz      (pz_q),
		.cx      (tab_rdata.x),
		.cy      (tab_rdata.y),
		.cz      (tab_rdata.z),
		.dist_s4 (dist_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_valid_q <= '0;
			count_q       <= '0;
			pend_q        <= 1'b0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			found_q       <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == S_SCAN);
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			if (ctl.tab_we) begin
				entry_valid_q[free_idx] <= 1'b1;
				count_q                 <= count_q + CNT_W'(1);
			end
			if (accept && is_pop) begin
				found_q <= 1'b0;
			end else if (better) begin
				found_q <= 1'b1;
			end
			if (state_q == S_FINISH) begin
				entry_valid_q[best_idx_q] <= 1'b0;
				count_q                   <= count_q - CNT_W'(1);
				pend_q                    <= 1'b1;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			scan_q <= '0;
		end else if (state_q == S_SCAN) begin
			scan_q <= scan_q + IDX_W'(1);
		end
		if (accept && is_pop) begin
			px_q <= req.player_x;
			py_q <= req.player_y;
			pz_q <= req.player_z;
		end
		idx_s1  <= scan_q;
		idx_s2  <= idx_s1;
		live_s2 <= entry_valid_q[idx_s1];
		rank_s2 <= rank_virt_s1;
		ent_s2  <= tab_rdata;
		idx_s3  <= idx_s2;
		live_s3 <= live_s2;
		rank_s3 <= rank_s2;
		ent_s3  <= ent_s2;
		idx_s4  <= idx_s3;
		live_s4 <= live_s3;
		rank_s4 <= rank_s3;
		ent_s4  <= ent_s3;
		if (better) begin
			best_d_q    <= dist_s4;
			best_rank_q <= rank_s4;
			best_idx_q  <= idx_s4;
			best_ent_q  <= ent_s4;
		end
		if (accept) begin
			res_ent_q <= '0;
			if (is_pop) begin
				res_status_q <= ST_EMPTY;
			end else if (full) begin
				res_status_q <= ST_FULL;
			end else begin
				res_status_q <= ST_PUSHED;
			end
		end
		if (state_q == S_FINISH) begin
			res_status_q <= ST_POPPED;
			res_ent_q    <= best_ent_q;
			pend_rank_q  <= best_rank_q;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_ent_q    <= res_ent_q;
			out_occ_q    <= OCC_W'(count_q);
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.status    = out_status_q;
	assign rsp.out_tag   = out_ent_q.tag;
	assign rsp.out_x     = out_ent_q.x;
	assign rsp.out_y     = out_ent_q.y;
	assign rsp.out_z     = out_ent_q.z;
	assign rsp.occupancy = out_occ_q;

endmodule
`default_nettype wire

FILE: src/nfcq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none
module nfcq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: src/nfcq_dist.sv
// Three-stage pipeline giving the squared distance from the player to a chunk centre.
`default_nettype none
module nfcq_dist (
	input  wire logic                               clk,
	input  wire logic signed [nfcq_pkg::POS_W-1:0]   px,
	input  wire logic signed [nfcq_pkg::POS_W-1:0]   py,
	input  wire logic signed [nfcq_pkg::POS_W-1:0]   pz,
	input  wire logic signed [nfcq_pkg::COORD_W-1:0] cx,
	input  wire logic signed [nfcq_pkg::COORD_W-1:0] cy,
	input  wire logic signed [nfcq_pkg::COORD_W-1:0] cz,
	output logic      [nfcq_pkg::SUM_W-1:0]          dist_s4
);
	import nfcq_pkg::*;

	localparam logic signed [DIFF_W-1:0] MUL_C = DIFF_W'(CENTRE_MUL);
	localparam logic signed [DIFF_W-1:0] OFS_C = DIFF_W'(CENTRE_OFS);

	logic signed [DIFF_W-1:0]   dx_d, dy_d, dz_d;
	logic signed [DIFF_W-1:0]   dx_s2, dy_s2, dz_s2;
	logic signed [2*DIFF_W-1:0] px2, py2, pz2;
	logic [SQ_W-1:0]            sx_s3, sy_s3, sz_s3;

	// The centre of a chunk lies half an edge above its lower corner.
	assign dx_d = DIFF_W'(px) - DIFF_W'(cx) * MUL_C - OFS_C;
	assign dy_d = DIFF_W'(py) - DIFF_W'(cy) * MUL_C - OFS_C;
	assign dz_d = DIFF_W'(pz) - DIFF_W'(cz) * MUL_C - OFS_C;

	assign px2 = dx_s2 * dx_s2;
	assign py2 = dy_s2 * dy_s2;
	assign pz2 = dz_s2 * dz_s2;

	always_ff @(posedge clk) begin
		dx_s2   <= dx_d;
		dy_s2   <= dy_d;
		dz_s2   <= dz_d;
		sx_s3   <= SQ_W'(px2);
		sy_s3   <= SQ_W'(py2);
		sz_s3   <= SQ_W'(pz2);
		dist_s4 <= SUM_W'(sx_s3) + SUM_W'(sy_s3) + SUM_W'(sz_s3);
	end

endmodule
`default_nettype wire
